@@ hw/rtl/h_bridge_drive_with_kick_and_brake_core_assert.svh @@
// Assertion macros used by the core RTL.
`ifndef H_BRIDGE_DRIVE_WITH_KICK_AND_BRAKE_CORE_ASSERT_SVH
`define H_BRIDGE_DRIVE_WITH_KICK_AND_BRAKE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define HBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HBD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/hbd_pkg.sv @@
package hbd_pkg;

    localparam int PWM_COUNT_MAX = 1000;
    localparam int SIDES         = 2;

    localparam int OUT_SLOTS    = 2;
    localparam int ACTIVE_SIDES = (SIDES < OUT_SLOTS) ? SIDES : OUT_SLOTS;
    localparam int SIDE_W       = 1;

    localparam int TGT_W   = 14;
    localparam int DUTY_W  = 14;
    localparam int MAG_W   = 13;
    localparam int TICK_W  = 7;
    localparam int COUNT_W = 10;
    localparam int FRAC_W  = 12;
    localparam int PWM_W   = 16;
    localparam int PROD1_W = 2 * MAG_W;
    localparam int PROD2_W = MAG_W + PWM_W;
    localparam int RAW_W   = PROD2_W - FRAC_W;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [MAG_W-1:0]        FULL_C     = MAG_W'(4096);
    localparam logic signed [TGT_W-1:0] TGT_MAX    = TGT_W'(4096);
    localparam logic signed [TGT_W-1:0] TGT_MIN    = -TGT_W'(4096);
    localparam logic [PWM_W-1:0]        PWM_MAX    = PWM_W'(PWM_COUNT_MAX);
    localparam logic [COUNT_W-1:0]      COAST_COUNT = COUNT_W'(PWM_COUNT_MAX);

    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KICK_DUTY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KICK_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_APPLY,
        ST_SCALE,
        ST_DRIVE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              capture;
        logic              map;
        logic              apply;
        logic              scale;
        logic              drive;
        logic              load;
        logic [SIDE_W-1:0] side;
    } t_cmd;

    function automatic logic [MAG_W-1:0] cap_full(input logic [MAG_W-1:0] v);
        return (v > FULL_C) ? FULL_C : v;
    endfunction

    function automatic logic signed [TGT_W-1:0] sat_target(
        input logic signed [TGT_W-1:0] t
    );
        logic signed [TGT_W-1:0] r;
        r = t;
        if (t > TGT_MAX) r = TGT_MAX;
        if (t < TGT_MIN) r = TGT_MIN;
        return r;
    endfunction

endpackage

@@ hw/rtl/h_bridge_drive_with_kick_and_brake_core.sv @@
// Two-sided H-bridge drive. Each input transaction carries a signed throttle
// target per side (4096 is full scale); the block maps it above min_run, applies
// a start kick from standstill, clamps to max_duty, brakes on a reversal and
// returns one output transaction with inverted-polarity pin counts (0 drives the
// pin high, 1000 drives it low). The sides are processed one after the other by
// a four-step datapath (map multiply, throttle update, clamp and PWM multiply,
// pin decision). After the last side the output register is loaded once the
// previous output has been taken, and the block returns to idle; it accepts a
// new item only while idle. Registers are written through the cfg channel, index
// per register: min_run, kick_duty, kick_ticks, brake_ticks, max_duty.
`include "h_bridge_drive_with_kick_and_brake_core_assert.svh"

module h_bridge_drive_with_kick_and_brake_core import hbd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [13:0] left_target, [27:14] right_target, [31:28] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [9:0] left_fwd_count, [19:10] left_rev_count,
    // [29:20] right_fwd_count, [39:30] right_rev_count
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    hbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    hbd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_targets   (s_axis_tdata[2*TGT_W-1:0]),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (m_axis_tdata)
    );

    `HBD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `HBD_ASSERT_SAME(a_left_pins, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[9:0] == COAST_COUNT) || (m_axis_tdata[19:10] == COAST_COUNT) || (m_axis_tdata[19:0] == '0))
    `HBD_ASSERT_SAME(a_right_pins, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[29:20] == COAST_COUNT) || (m_axis_tdata[39:30] == COAST_COUNT) || (m_axis_tdata[39:20] == '0))

endmodule

@@ hw/rtl/hbd_ctrl.sv @@
module hbd_ctrl import hbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam logic [SIDE_W-1:0] LAST_SIDE = SIDE_W'(ACTIVE_SIDES - 1);

    t_state            r_state, n_state;
    logic [SIDE_W-1:0] r_side, n_side;
    logic              r_out_valid, n_out_valid;
    logic              w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_side      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_side      <= n_side;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_side  = r_side;
        case (r_state)
            ST_IDLE: begin
                n_side = '0;
                if (i_in_valid) n_state = ST_MAP;
            end
            ST_MAP:   n_state = ST_APPLY;
            ST_APPLY: n_state = ST_SCALE;
            ST_SCALE: n_state = ST_DRIVE;
            ST_DRIVE: begin
                if (r_side == LAST_SIDE) begin
                    n_state = ST_DONE;
                end else begin
                    n_side  = r_side + 1'b1;
                    n_state = ST_MAP;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.side    = r_side;
        o_in_ready    = 1'b0;
        w_load        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_MAP:   o_cmd.map   = 1'b1;
            ST_APPLY: o_cmd.apply = 1'b1;
            ST_SCALE: o_cmd.scale = 1'b1;
            ST_DRIVE: o_cmd.drive = 1'b1;
            ST_DONE:  w_load      = !r_out_valid || i_out_ready;
            default: ;
        endcase
        o_cmd.load = w_load;
    end

    assign n_out_valid = w_load || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/hbd_datapath.sv @@
module hbd_datapath import hbd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [2*TGT_W-1:0]    i_targets,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    logic [MAG_W-1:0]  r_min_run, r_kick_duty, r_max_duty;
    logic [TICK_W-1:0] r_kick_ticks, r_brake_ticks;

    logic signed [DUTY_W-1:0] r_applied [ACTIVE_SIDES];
    logic [TICK_W-1:0]        r_kick    [ACTIVE_SIDES];
    logic [TICK_W-1:0]        r_brake   [ACTIVE_SIDES];
    logic signed [DUTY_W-1:0] r_prev    [ACTIVE_SIDES];

    logic signed [TGT_W-1:0]  r_tgt [OUT_SLOTS];
    logic signed [TGT_W-1:0]  r_t;
    logic [PROD1_W-1:0]       r_prod1;
    logic signed [DUTY_W-1:0] r_d;
    logic [PROD2_W-1:0]       r_prod2;
    logic [COUNT_W-1:0]       r_fwd [OUT_SLOTS];
    logic [COUNT_W-1:0]       r_rev [OUT_SLOTS];
    logic [OUT_DATA_W-1:0]    r_out;

    logic [MAG_W-1:0]         w_lo, w_m, w_k, w_lim, w_mag, w_abs;
    logic signed [TGT_W-1:0]  w_t;
    logic signed [DUTY_W-1:0] w_mapped, w_d, w_lim_s;
    logic signed [DUTY_W-1:0] n_applied;
    logic [TICK_W-1:0]        n_kick, n_brake;
    logic [RAW_W-1:0]         w_raw;
    logic [PWM_W-1:0]         w_act;
    logic [COUNT_W-1:0]       n_fwd, n_rev;
    logic signed [DUTY_W-1:0] w_p;

    assign w_lo    = cap_full(r_min_run);
    assign w_k     = cap_full(r_kick_duty);
    assign w_lim   = cap_full(r_max_duty);
    assign w_lim_s = $signed({1'b0, w_lim});

    // map step
    always_comb begin
        w_t   = sat_target(r_tgt[i_cmd.side]);
        w_mag = w_t[TGT_W-1] ? MAG_W'(-w_t) : MAG_W'(w_t);
    end

    // throttle update
    always_comb begin
        w_m       = w_lo + MAG_W'(r_prod1 >> FRAC_W);
        w_mapped  = r_t[TGT_W-1] ? -$signed({1'b0, w_m}) : $signed({1'b0, w_m});
        n_applied = r_applied[i_cmd.side];
        n_kick    = r_kick[i_cmd.side];
        if (r_t == '0) begin
            n_applied = '0;
            n_kick    = '0;
        end else if (r_kick[i_cmd.side] != '0) begin
            n_kick = r_kick[i_cmd.side] - 1'b1;
            if (n_kick == '0) n_applied = w_mapped;
        end else if (r_applied[i_cmd.side] == '0) begin
            n_kick    = r_kick_ticks;
            n_applied = r_t[TGT_W-1] ? -$signed({1'b0, w_k}) : $signed({1'b0, w_k});
        end else begin
            n_applied = w_mapped;
        end
    end

    // clamp step
    always_comb begin
        w_d = r_applied[i_cmd.side];
        if (w_d > w_lim_s) w_d = w_lim_s;
        if (w_d < -w_lim_s) w_d = -w_lim_s;
        w_abs = w_d[DUTY_W-1] ? MAG_W'(-w_d) : MAG_W'(w_d);
    end

    // pin drive
    always_comb begin
        w_raw = RAW_W'(r_prod2 >> FRAC_W);
        if (w_raw > RAW_W'(PWM_MAX)) w_raw = RAW_W'(PWM_MAX);
        w_act   = PWM_MAX - PWM_W'(w_raw);
        w_p     = r_prev[i_cmd.side];
        n_brake = '0;
        n_fwd   = COAST_COUNT;
        n_rev   = COAST_COUNT;
        if (r_brake[i_cmd.side] != '0) begin
            n_brake = r_brake[i_cmd.side] - 1'b1;
            n_fwd   = '0;
            n_rev   = '0;
        end else if (r_d == '0) begin
            n_fwd = COAST_COUNT;
            n_rev = COAST_COUNT;
        end else if ((w_p > 0 && r_d < 0) || (w_p < 0 && r_d > 0)) begin
            n_brake = r_brake_ticks;
            n_fwd   = '0;
            n_rev   = '0;
        end else if (r_d > 0) begin
            n_fwd = COUNT_W'(w_act);
        end else begin
            n_rev = COUNT_W'(w_act);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_run     <= MAG_W'(410);
            r_kick_duty   <= MAG_W'(2867);
            r_kick_ticks  <= TICK_W'(5);
            r_brake_ticks <= TICK_W'(5);
            r_max_duty    <= MAG_W'(4096);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MIN_RUN:     r_min_run     <= i_cfg_data;
                REG_KICK_DUTY:   r_kick_duty   <= i_cfg_data;
                REG_KICK_TICKS:  r_kick_ticks  <= i_cfg_data[TICK_W-1:0];
                REG_BRAKE_TICKS: r_brake_ticks <= i_cfg_data[TICK_W-1:0];
                REG_MAX_DUTY:    r_max_duty    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < ACTIVE_SIDES; s++) begin
                r_applied[s] <= '0;
                r_kick[s]    <= '0;
                r_brake[s]   <= '0;
                r_prev[s]    <= '0;
            end
        end else begin
            if (i_cmd.apply) begin
                r_applied[i_cmd.side] <= n_applied;
                r_kick[i_cmd.side]    <= n_kick;
            end
            if (i_cmd.drive) begin
                r_brake[i_cmd.side] <= n_brake;
                if (n_brake == '0) r_prev[i_cmd.side] <= r_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int s = 0; s < OUT_SLOTS; s++) begin
                r_tgt[s] <= i_targets[s*TGT_W +: TGT_W];
                r_fwd[s] <= COAST_COUNT;
                r_rev[s] <= COAST_COUNT;
            end
        end
        if (i_cmd.map) begin
            r_t     <= w_t;
            r_prod1 <= PROD1_W'(w_mag) * PROD1_W'(MAG_W'(FULL_C - w_lo));
        end
        if (i_cmd.scale) begin
            r_d     <= w_d;
            r_prod2 <= PROD2_W'(w_abs) * PROD2_W'(PWM_MAX);
        end
        if (i_cmd.drive) begin
            r_fwd[i_cmd.side] <= n_fwd;
            r_rev[i_cmd.side] <= n_rev;
        end
        if (i_cmd.load) begin
            r_out <= {r_rev[1], r_fwd[1], r_rev[0], r_fwd[0]};
        end
    end

    assign o_out_data = r_out;

endmodule
